FILE: hdl/rlkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlkd_pkg
// Shared sizes, types and reset values of the resistor ladder keypad decoder.
// ----------------------------------------------------------------------------
package rlkd_pkg;

    localparam int NUM_LEVELS   = 8;
    localparam int NUM_BUTTONS  = 3;
    localparam int ADC_BITS     = 12;
    localparam int TIME_BITS    = 32;

    localparam int LEVEL_BITS   = $clog2(NUM_LEVELS);
    localparam int BTN_IDX_BITS = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int BTN_NUM_BITS = 2;
    localparam int OUT_MASK_BITS = 3;

    // stream payload widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((ADC_BITS + TIME_BITS + 7) / 8) * 8;
    localparam int M_FIELDS_W = BTN_NUM_BITS + 1 + TIME_BITS + OUT_MASK_BITS;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    // bit positions of the result fields in m_tdata
    localparam int M_PRESSED_POS = BTN_NUM_BITS;
    localparam int M_ELAPSED_LSB = BTN_NUM_BITS + 1;
    localparam int M_MASK_LSB    = BTN_NUM_BITS + 1 + TIME_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef logic [ADC_BITS-1:0]    adc_t;
    typedef logic [TIME_BITS-1:0]   time_t;
    typedef logic [LEVEL_BITS-1:0]  level_idx_t;
    typedef logic [NUM_BUTTONS-1:0] btn_vec_t;

    // one decoded sample that changes at least one button
    typedef struct packed {
        level_idx_t mask;
        btn_vec_t   changed;
        time_t      stamp;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic adc_t level_reset(input int idx);
        logic [15:0] v;
        case (idx)
            0:       v = 16'd3308;
            1:       v = 16'd2653;
            2:       v = 16'd2196;
            3:       v = 16'd1878;
            4:       v = 16'd1667;
            5:       v = 16'd1471;
            6:       v = 16'd1333;
            7:       v = 16'd1197;
            default: v = 16'd0;
        endcase
        return adc_t'(v);
    endfunction

endpackage

FILE: hdl/resistor_ladder_keypad_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resistor_ladder_keypad_decoder
// Decodes ladder ADC samples into button masks and per-button change events.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per ADC sample, adc_code with its millisecond time.
//   m_ channel: one word per button whose state changed, lowest button first;
//   tlast marks the final event of a sample. A sample with no change gives
//   no word at all.
//   cfg_we/cfg_index/cfg_wdata write ladder level 0..7; write only when idle.
// Timing:
//   a sample's first event passes the stage-1 registers, the queue and the
//   output register. The front takes one sample per cycle unless the queue is
//   full and the sample changed; the back sends one event per cycle while
//   m_tready allows, one per changed button. A 4-deep queue sits between them.
// Reset: levels return to their default codes, the previous mask to zero,
//   all change times to zero, queue and output are emptied.
// Stall: while m_tready is low the output word holds; the queue fills and
//   then s_tready drops until the back drains it.
// ----------------------------------------------------------------------------
module resistor_ladder_keypad_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [rlkd_pkg::LEVEL_BITS-1:0]     cfg_index,
    input  logic [rlkd_pkg::ADC_BITS-1:0]       cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // adc_code, time_now
    input  logic [rlkd_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // button_number, pressed, elapsed_ms, button_mask
    output logic [rlkd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    logic              q_push;
    logic              q_pop;
    rlkd_pkg::entry_t  q_entry;
    rlkd_pkg::entry_t  q_head;
    rlkd_pkg::qstat_t  q_stat;

    rlkd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .qstat_i   (q_stat),
        .push_o    (q_push),
        .entry_o   (q_entry)
    );

    rlkd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (q_push),
        .entry_i (q_entry),
        .pop_i   (q_pop),
        .head_o  (q_head),
        .qstat_o (q_stat)
    );

    rlkd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_i   (q_head),
        .qstat_i  (q_stat),
        .pop_o    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    logic [rlkd_pkg::BTN_NUM_BITS-1:0]  out_num;
    logic [rlkd_pkg::OUT_MASK_BITS-1:0] out_mask;
    logic [rlkd_pkg::OUT_MASK_BITS-1:0] out_bit;

    assign out_num  = m_tdata[rlkd_pkg::BTN_NUM_BITS-1:0];
    assign out_mask = m_tdata[rlkd_pkg::M_MASK_LSB +: rlkd_pkg::OUT_MASK_BITS];
    assign out_bit  = out_mask >> (out_num - rlkd_pkg::BTN_NUM_BITS'(1));

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_button_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_num != '0))
        else $error("event with button number zero");

    a_pressed_matches_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_bit[0] == m_tdata[rlkd_pkg::M_PRESSED_POS]))
        else $error("pressed state disagrees with decoded mask");

endmodule

FILE: hdl/rlkd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlkd_front
// Holds the ladder levels, takes samples, finds the nearest level and queues
// the samples whose button mask changed.
// ----------------------------------------------------------------------------
module rlkd_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [rlkd_pkg::LEVEL_BITS-1:0]     cfg_index,
    input  logic [rlkd_pkg::ADC_BITS-1:0]       cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rlkd_pkg::S_TDATA_W-1:0]      s_tdata,
    input  rlkd_pkg::qstat_t                    qstat_i,
    output logic                                push_o,
    output rlkd_pkg::entry_t                    entry_o
);

    rlkd_pkg::adc_t       level_reg [rlkd_pkg::NUM_LEVELS];
    rlkd_pkg::adc_t       dist_reg  [rlkd_pkg::NUM_LEVELS];
    rlkd_pkg::adc_t       gap_reg;
    rlkd_pkg::time_t      stamp_reg;
    logic                 s1_valid_reg;
    rlkd_pkg::level_idx_t prev_mask_reg;

    rlkd_pkg::adc_t       code;
    rlkd_pkg::adc_t       best;
    rlkd_pkg::level_idx_t best_idx;
    rlkd_pkg::level_idx_t mask;
    rlkd_pkg::btn_vec_t   changed;
    logic                 s1_go;

    assign code = s_tdata[rlkd_pkg::ADC_BITS-1:0];

    function automatic rlkd_pkg::adc_t adist(input rlkd_pkg::adc_t a,
                                             input rlkd_pkg::adc_t b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // level registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rlkd_pkg::NUM_LEVELS; i++) begin
                level_reg[i] <= rlkd_pkg::level_reset(i);
            end
        end else if (cfg_we && (32'(cfg_index) < rlkd_pkg::NUM_LEVELS)) begin
            level_reg[cfg_index] <= cfg_wdata;
        end
    end

    // stage 1: distances to every level
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            for (int i = 0; i < rlkd_pkg::NUM_LEVELS; i++) begin
                dist_reg[i] <= adist(level_reg[i], code);
            end
            gap_reg   <= adist(level_reg[rlkd_pkg::NUM_LEVELS-2],
                               level_reg[rlkd_pkg::NUM_LEVELS-1]);
            stamp_reg <= s_tdata[rlkd_pkg::ADC_BITS +: rlkd_pkg::TIME_BITS];
        end
    end

    // nearest level: running minimum seeded with level 0's code, strict less-than
    always_comb begin
        best     = level_reg[0];
        best_idx = '0;
        for (int i = 0; i < rlkd_pkg::NUM_LEVELS; i++) begin
            if (dist_reg[i] < best) begin
                best     = dist_reg[i];
                best_idx = rlkd_pkg::LEVEL_BITS'(i);
            end
        end
        if ({best, 1'b0} <= {1'b0, gap_reg}) begin
            mask = best_idx;
        end else begin
            mask = '0;
        end
        changed = rlkd_pkg::btn_vec_t'(mask ^ prev_mask_reg);
    end

    assign s1_go    = (changed == '0) || !qstat_i.full;
    assign s_tready = !s1_valid_reg || s1_go;
    assign push_o   = s1_valid_reg && (changed != '0) && !qstat_i.full;

    assign entry_o.mask    = mask;
    assign entry_o.changed = changed;
    assign entry_o.stamp   = stamp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            prev_mask_reg <= '0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_valid_reg && s1_go) begin
                prev_mask_reg <= mask;
            end
        end
    end

endmodule

FILE: hdl/rlkd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlkd_queue
// Short first-in first-out queue of decoded samples between front and back.
// ----------------------------------------------------------------------------
module rlkd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_i,
    input  rlkd_pkg::entry_t  entry_i,
    input  logic              pop_i,
    output rlkd_pkg::entry_t  head_o,
    output rlkd_pkg::qstat_t  qstat_o
);

    rlkd_pkg::entry_t                slot_reg [rlkd_pkg::QUEUE_DEPTH];
    logic [rlkd_pkg::QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rlkd_pkg::QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [rlkd_pkg::QPTR_BITS:0]    count_reg, count_next;

    assign head_o        = slot_reg[rd_ptr_reg];
    assign qstat_o.full  = (count_reg == (rlkd_pkg::QPTR_BITS+1)'(rlkd_pkg::QUEUE_DEPTH));
    assign qstat_o.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + rlkd_pkg::QPTR_BITS'(push_i);
        rd_ptr_next = rd_ptr_reg + rlkd_pkg::QPTR_BITS'(pop_i);
        count_next  = count_reg + (rlkd_pkg::QPTR_BITS+1)'(push_i)
                                - (rlkd_pkg::QPTR_BITS+1)'(pop_i);
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            slot_reg[wr_ptr_reg] <= entry_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/rlkd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlkd_back
// Turns each queued sample into one event per changed button, lowest button
// first, and keeps the per-button change times.
// ----------------------------------------------------------------------------
module rlkd_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  rlkd_pkg::entry_t                 head_i,
    input  rlkd_pkg::qstat_t                 qstat_i,
    output logic                             pop_o,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rlkd_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);

    rlkd_pkg::time_t                    change_time_reg [rlkd_pkg::NUM_BUTTONS];
    rlkd_pkg::btn_vec_t                 done_reg, done_next;
    logic                               m_valid_reg;
    logic [rlkd_pkg::M_TDATA_W-1:0]     m_data_reg, m_data_next;
    logic                               m_last_reg, m_last_next;

    rlkd_pkg::btn_vec_t                 remaining;
    rlkd_pkg::btn_vec_t                 sel_bit;
    logic [rlkd_pkg::BTN_IDX_BITS-1:0]  sel;
    logic                               found;
    logic                               emit;
    logic                               last;
    rlkd_pkg::time_t                    elapsed;
    logic [rlkd_pkg::BTN_NUM_BITS-1:0]  btn_num;

    assign remaining = head_i.changed & ~done_reg;
    assign emit      = !qstat_i.empty && (!m_valid_reg || m_tready);

    // lowest button still to report
    always_comb begin
        sel     = '0;
        sel_bit = '0;
        found   = 1'b0;
        for (int b = 0; b < rlkd_pkg::NUM_BUTTONS; b++) begin
            if (remaining[b] && !found) begin
                found      = 1'b1;
                sel        = rlkd_pkg::BTN_IDX_BITS'(b);
                sel_bit[b] = 1'b1;
            end
        end
        last    = ((remaining & ~sel_bit) == '0);
        elapsed = head_i.stamp - change_time_reg[sel];
        btn_num = rlkd_pkg::BTN_NUM_BITS'(32'(sel) + 32'd1);

        m_data_next = '0;
        m_data_next[rlkd_pkg::BTN_NUM_BITS-1:0] = btn_num;
        m_data_next[rlkd_pkg::M_PRESSED_POS] = head_i.mask[sel];
        m_data_next[rlkd_pkg::M_ELAPSED_LSB +: rlkd_pkg::TIME_BITS] = elapsed;
        m_data_next[rlkd_pkg::M_MASK_LSB +: rlkd_pkg::OUT_MASK_BITS] =
            rlkd_pkg::OUT_MASK_BITS'(head_i.mask);
        m_last_next = last;

        if (emit) begin
            done_next = last ? '0 : (done_reg | sel_bit);
        end else begin
            done_next = done_reg;
        end
    end

    assign pop_o    = emit && last;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= m_data_next;
            m_last_reg <= m_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            done_reg    <= '0;
            for (int b = 0; b < rlkd_pkg::NUM_BUTTONS; b++) begin
                change_time_reg[b] <= '0;
            end
        end else begin
            done_reg <= done_next;
            if (emit) begin
                m_valid_reg          <= 1'b1;
                change_time_reg[sel] <= head_i.stamp;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule
